FILE: sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	// Input field widths
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;

	// Pipeline depth, one valid bit per stage
	localparam int PIPE_DEPTH = 9;
	typedef logic [PIPE_DEPTH-1:0] stage_en_t;

	// Default channel width
	localparam int CHANNEL_BITS_DEF = 16;

	// Levels are exact integers in units of 1/6000 percent, at most 600000
	localparam int LEVEL_W = 20;
	localparam int PROD_W  = 14;
	localparam int OFF_W   = 6;

	localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
	localparam logic [HUE_W-1:0]   HUE_WRAP  = 9'd360;
	localparam logic [LEVEL_W-1:0] V_SCALE   = 20'd6000;
	localparam logic [LEVEL_W-1:0] MIN_SCALE = 20'd60;

	// Division by 600000 = 64 * 9375; the 9375 part uses a reciprocal
	localparam int Y_W         = 33;
	localparam int QE_W        = 20;
	localparam int REM_W       = 15;
	localparam int RECIP_SHIFT = 34;
	localparam int RECIP_W     = 21;
	localparam int DIV_BASE_I  = 9375;
	localparam logic [REM_W-1:0]   DIV_BASE   = 15'd9375;
	localparam logic [RECIP_W-1:0] RECIP_MUL  = 21'd1832519;
	localparam logic [Y_W-1:0]     ROUND_HALF = 33'd300000;
	localparam int POW2_SHIFT = 6;

	// 60-degree hue sectors
	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	// Per-channel levels leaving the level stages
	typedef struct packed {
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
	} rgb_level_t;

endpackage

FILE: sv/hsv2rgb_flow.sv
`timescale 1ns / 1ps

module hsv2rgb_flow (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hsv2rgb_pkg::stage_en_t en
);

	localparam int D = hsv2rgb_pkg::PIPE_DEPTH;

	hsv2rgb_pkg::stage_en_t vld_q;

	// A stage moves when it is empty or the next one moves
	always_comb begin
		en[D-1] = !vld_q[D-1] || out_ready;
		for (int k = D - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < D; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[D-1];

endmodule

FILE: sv/hsv2rgb_levels.sv
`timescale 1ns / 1ps

module hsv2rgb_levels (
	input  logic                                clk,
	input  hsv2rgb_pkg::stage_en_t              en,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_deg,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]       sat_pct,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]       val_pct,
	output hsv2rgb_pkg::rgb_level_t             level
);

	localparam int LW = hsv2rgb_pkg::LEVEL_W;
	localparam int PW = hsv2rgb_pkg::PROD_W;
	localparam int OW = hsv2rgb_pkg::OFF_W;
	localparam int HW = hsv2rgb_pkg::HUE_W;

	// Stage 1: wrap, clamp, sector split
	hsv2rgb_pkg::sector_t          sect_s1;
	logic [OW-1:0]                 off_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0] sat_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0] val_s1;

	// Stage 2: products of the percents
	hsv2rgb_pkg::sector_t sect_s2;
	logic [OW-1:0]        off_s2;
	logic [PW-1:0]        sv_s2;
	logic [PW-1:0]        nsv_s2;
	logic [LW-1:0]        lv_s2;

	// Stage 3: levels v, vmin, a
	hsv2rgb_pkg::sector_t sect_s3;
	logic [LW-1:0]        lv_s3;
	logic [LW-1:0]        lmin_s3;
	logic [LW-1:0]        la_s3;

	// Stage 4: selected channel levels
	hsv2rgb_pkg::rgb_level_t level_s4;

	logic [HW-1:0]        hue_w;
	hsv2rgb_pkg::sector_t sect_d;
	logic [HW-1:0]        off_d;
	logic [LW-1:0]        linc;
	logic [LW-1:0]        ldec;

	// Hue below 512 wraps with one subtract, then split into 60-degree sectors
	always_comb begin
		hue_w = (hue_deg >= hsv2rgb_pkg::HUE_WRAP) ? hue_deg - hsv2rgb_pkg::HUE_WRAP : hue_deg;
		if (hue_w >= 9'd300) begin
			sect_d = hsv2rgb_pkg::SECT_MAG_RED;
			off_d  = hue_w - 9'd300;
		end else if (hue_w >= 9'd240) begin
			sect_d = hsv2rgb_pkg::SECT_BLU_MAG;
			off_d  = hue_w - 9'd240;
		end else if (hue_w >= 9'd180) begin
			sect_d = hsv2rgb_pkg::SECT_CYN_BLU;
			off_d  = hue_w - 9'd180;
		end else if (hue_w >= 9'd120) begin
			sect_d = hsv2rgb_pkg::SECT_GRN_CYN;
			off_d  = hue_w - 9'd120;
		end else if (hue_w >= 9'd60) begin
			sect_d = hsv2rgb_pkg::SECT_YEL_GRN;
			off_d  = hue_w - 9'd60;
		end else begin
			sect_d = hsv2rgb_pkg::SECT_RED_YEL;
			off_d  = hue_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sect_s1 <= sect_d;
			off_s1  <= off_d[OW-1:0];
			sat_s1  <= (sat_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : sat_pct;
			val_s1  <= (val_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : val_pct;
		end
	end

	// s*v, (100-s)*v and 6000*v
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sect_s2 <= sect_s1;
			off_s2  <= off_s1;
			sv_s2   <= PW'(sat_s1) * PW'(val_s1);
			nsv_s2  <= PW'(hsv2rgb_pkg::PCT_MAX - sat_s1) * PW'(val_s1);
			lv_s2   <= LW'(val_s1) * hsv2rgb_pkg::V_SCALE;
		end
	end

	// vmin = 60*(100-s)*v, a = s*v*offset
	always_ff @(posedge clk) begin
		if (en[2]) begin
			sect_s3 <= sect_s2;
			lv_s3   <= lv_s2;
			lmin_s3 <= LW'(nsv_s2) * hsv2rgb_pkg::MIN_SCALE;
			la_s3   <= LW'(sv_s2) * LW'(off_s2);
		end
	end

	// Rising and falling levels, picked per channel by sector
	assign linc = lmin_s3 + la_s3;
	assign ldec = lv_s3 - la_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			case (sect_s3)
				hsv2rgb_pkg::SECT_RED_YEL: level_s4 <= '{r: lv_s3,   g: linc,    b: lmin_s3};
				hsv2rgb_pkg::SECT_YEL_GRN: level_s4 <= '{r: ldec,    g: lv_s3,   b: lmin_s3};
				hsv2rgb_pkg::SECT_GRN_CYN: level_s4 <= '{r: lmin_s3, g: lv_s3,   b: linc};
				hsv2rgb_pkg::SECT_CYN_BLU: level_s4 <= '{r: lmin_s3, g: ldec,    b: lv_s3};
				hsv2rgb_pkg::SECT_BLU_MAG: level_s4 <= '{r: linc,    g: lmin_s3, b: lv_s3};
				default:                   level_s4 <= '{r: lv_s3,   g: lmin_s3, b: ldec};
			endcase
		end
	end

	assign level = level_s4;

endmodule

FILE: sv/hsv2rgb_scale.sv
`timescale 1ns / 1ps

// One channel: level * FS / 600000, rounded, saturated. Stages 5 to 9.
module hsv2rgb_scale #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                              clk,
	input  hsv2rgb_pkg::stage_en_t            en,
	input  logic [hsv2rgb_pkg::LEVEL_W-1:0]   level,
	output logic [CHANNEL_BITS-1:0]           chan
);

	localparam int LW   = hsv2rgb_pkg::LEVEL_W;
	localparam int YW   = hsv2rgb_pkg::Y_W;
	localparam int QW   = hsv2rgb_pkg::QE_W;
	localparam int RW   = hsv2rgb_pkg::REM_W;
	localparam int CLW  = CHANNEL_BITS + hsv2rgb_pkg::POW2_SHIFT;
	localparam int TW   = CLW + 1;
	localparam int YPW  = YW + hsv2rgb_pkg::RECIP_W;
	localparam longint unsigned FS = (64'd1 << CHANNEL_BITS) - 64'd1;
	// FS = FS_DIV * 9375 + FS_MOD
	localparam longint unsigned FS_DIV = FS / hsv2rgb_pkg::DIV_BASE_I;
	localparam longint unsigned FS_MOD = FS % hsv2rgb_pkg::DIV_BASE_I;

	logic [CLW-1:0] cl_s5, cl_s6, cl_s7;
	logic [YW-1:0]  y_s5, y_s6;
	logic [QW-1:0]  qe_s6, qe_s7;
	logic [RW-1:0]  rem_s7;
	logic [TW-1:0]  tot_s8;
	logic [CHANNEL_BITS-1:0] chan_s9;

	logic [LW+CLW-1:0] cl_full;
	logic [YW:0]       y_full;
	logic [YPW-1:0]    yp;
	logic [RW-1:0]     prod_lo;
	logic              corr;
	logic [TW-hsv2rgb_pkg::POW2_SHIFT-1:0] q;

	// floor(n/9375) = FS_DIV*level + floor((FS_MOD*level + 300000)/9375)
	assign cl_full = (LW + CLW)'(level) * (LW + CLW)'(FS_DIV);
	assign y_full  = (YW + 1)'(level) * (YW + 1)'(FS_MOD) + (YW + 1)'(hsv2rgb_pkg::ROUND_HALF);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			cl_s5 <= cl_full[CLW-1:0];
			y_s5  <= y_full[YW-1:0];
		end
	end

	// Reciprocal estimate, low by at most one
	assign yp = YPW'(y_s5) * YPW'(hsv2rgb_pkg::RECIP_MUL);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			cl_s6 <= cl_s5;
			y_s6  <= y_s5;
			qe_s6 <= yp[hsv2rgb_pkg::RECIP_SHIFT +: QW];
		end
	end

	// Remainder is below twice the divisor, so its low bits suffice
	assign prod_lo = RW'(qe_s6 * QW'(hsv2rgb_pkg::DIV_BASE));

	always_ff @(posedge clk) begin
		if (en[6]) begin
			cl_s7  <= cl_s6;
			qe_s7  <= qe_s6;
			rem_s7 <= y_s6[RW-1:0] - prod_lo;
		end
	end

	assign corr = (rem_s7 >= hsv2rgb_pkg::DIV_BASE);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			tot_s8 <= TW'(cl_s7) + TW'(qe_s7) + TW'(corr);
		end
	end

	// Divide by 64 and clip at the top code
	assign q = tot_s8[TW-1:hsv2rgb_pkg::POW2_SHIFT];

	always_ff @(posedge clk) begin
		if (en[8]) begin
			chan_s9 <= q[CHANNEL_BITS] ? {CHANNEL_BITS{1'b1}} : q[CHANNEL_BITS-1:0];
		end
	end

	assign chan = chan_s9;

endmodule

FILE: sv/hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          tdata fields (low bit first)
// s_*       in   s_tvalid/s_tready  hue_deg[8:0] sat_pct[15:9] val_pct[22:16]
// m_*       out  m_tvalid/m_tready  red, green, blue, CHANNEL_BITS each
//
// Nine register stages; one request per cycle sustained while m_tready stays high.
// The stage count is set by the two multiply levels of the level path and
// the reciprocal divide by 600000 in each channel lane.
// Reset clears only the stage valid bits; data registers carry no reset.
// Stalls stop only the full stages in front of the hold-up; empty stages
// keep filling, so s_tready stays high until all nine stages are occupied.
module hsv_to_rgb_converter_unit #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF,
	localparam int OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,  // hue_deg[8:0], sat_pct[15:9], val_pct[22:16], 0
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // red, green, blue, zero fill
);

	hsv2rgb_pkg::stage_en_t  en;
	hsv2rgb_pkg::rgb_level_t level;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	// Stage handshake
	hsv2rgb_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.en        (en)
	);

	// Hue decode and level select
	hsv2rgb_levels u_levels (
		.clk     (clk),
		.en      (en),
		.hue_deg (s_tdata[8:0]),
		.sat_pct (s_tdata[15:9]),
		.val_pct (s_tdata[22:16]),
		.level   (level)
	);

	// Channel lanes
	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_r (
		.clk   (clk),
		.en    (en),
		.level (level.r),
		.chan  (red)
	);

	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_g (
		.clk   (clk),
		.en    (en),
		.level (level.g),
		.chan  (green)
	);

	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_b (
		.clk   (clk),
		.en    (en),
		.level (level.b),
		.chan  (blue)
	);

	assign m_tdata = OUT_W'({blue, green, red});

endmodule

FILE: sv/hsv2rgb_chk.sv
`timescale 1ns / 1ps

module hsv2rgb_chk #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF,
	localparam int OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int D  = hsv2rgb_pkg::PIPE_DEPTH;
	localparam int CW = $clog2(D + 1);

	logic [CW-1:0] cnt_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (!in_acc && out_acc) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// No result without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("result shown with nothing in flight");

	// Never more in flight than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(D))
		else $error("more requests in flight than stages");

	// Input backs up only when every stage is full and the output is stalled
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (cnt_q == CW'(D)) && !m_tready)
		else $error("input stalled while pipeline has room");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_chk #(.CHANNEL_BITS(CHANNEL_BITS)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/hsv_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_tb;

	localparam int CB = hsv2rgb_pkg::CHANNEL_BITS_DEF;
	localparam int HW = hsv2rgb_pkg::HUE_W;
	localparam int PW = hsv2rgb_pkg::PCT_W;
	localparam int OUT_W = ((3 * CB + 7) / 8) * 8;
	localparam longint unsigned FULL_CODE = (64'd1 << CB) - 1;
	localparam longint unsigned LEVEL_DIV = 600000;
	localparam longint unsigned LEVEL_RND = 300000;
	localparam int RANDOM_PER_PHASE = 250;
	localparam int DRAIN_LIMIT = 5000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
	} rgb_code_t;

	// Color predictor and store of expected channel codes
	class rgb_scoreboard;
		rgb_code_t expected_rgb[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// level in 1/6000 percent to channel code, rounded to nearest
		function logic [CB-1:0] level_to_code(longint unsigned level);
			longint unsigned q;
			q = (level * FULL_CODE + LEVEL_RND) / LEVEL_DIV;
			if (q > FULL_CODE)
				q = FULL_CODE;
			return q[CB-1:0];
		endfunction

		function rgb_code_t predict_rgb(logic [HW-1:0] hue_in, logic [PW-1:0] sat_in,
			logic [PW-1:0] val_in);
			longint unsigned hue, s, v, off, lv, lmin, la, linc, ldec, r, g, b;
			hsv2rgb_pkg::sector_t sect;
			rgb_code_t c;
			hue = hue_in % 360;
			s = (sat_in > hsv2rgb_pkg::PCT_MAX) ? 100 : sat_in;
			v = (val_in > hsv2rgb_pkg::PCT_MAX) ? 100 : val_in;
			sect = hsv2rgb_pkg::sector_t'(hue / 60);
			off = hue % 60;
			lv = 6000 * v;
			lmin = 60 * (100 - s) * v;
			la = s * v * off;
			linc = lmin + la;
			ldec = lv - la;
			case (sect)
				hsv2rgb_pkg::SECT_RED_YEL: begin r = lv;   g = linc; b = lmin; end
				hsv2rgb_pkg::SECT_YEL_GRN: begin r = ldec; g = lv;   b = lmin; end
				hsv2rgb_pkg::SECT_GRN_CYN: begin r = lmin; g = lv;   b = linc; end
				hsv2rgb_pkg::SECT_CYN_BLU: begin r = lmin; g = ldec; b = lv;   end
				hsv2rgb_pkg::SECT_BLU_MAG: begin r = linc; g = lmin; b = lv;   end
				default:                   begin r = lv;   g = lmin; b = ldec; end
			endcase
			c.red = level_to_code(r);
			c.green = level_to_code(g);
			c.blue = level_to_code(b);
			return c;
		endfunction

		function void note_request(logic [23:0] req);
			expected_rgb.push_back(predict_rgb(req[8:0], req[15:9], req[22:16]));
		endfunction

		task check_result(logic [OUT_W-1:0] data);
			rgb_code_t exp_c;
			logic [CB-1:0] red, green, blue;
			red = data[CB-1:0];
			green = data[2*CB-1:CB];
			blue = data[3*CB-1:2*CB];
			if (expected_rgb.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", data));
				return;
			end
			exp_c = expected_rgb.pop_front();
			if (red !== exp_c.red)
				report_mismatch($sformatf("red got %0d exp %0d", red, exp_c.red));
			if (green !== exp_c.green)
				report_mismatch($sformatf("green got %0d exp %0d", green, exp_c.green));
			if (blue !== exp_c.blue)
				report_mismatch($sformatf("blue got %0d exp %0d", blue, exp_c.blue));
		endtask

		function int pending();
			return expected_rgb.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	rgb_scoreboard sb = new();

	hsv_to_rgb_converter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Request and result monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_request(input logic [HW-1:0] hue, input logic [PW-1:0] sat,
		input logic [PW-1:0] val);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, sat, hue};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [PW-1:0] rand_pct();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return PW'($urandom_range(127, 101));
		if (r < 12)
			return ($urandom_range(1) != 0) ? hsv2rgb_pkg::PCT_MAX : '0;
		return PW'($urandom_range(100));
	endfunction

	function automatic logic [HW-1:0] rand_hue();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return HW'($urandom_range(511, 360));
		if (r < 20)
			return HW'(60 * $urandom_range(5) + (($urandom_range(1) != 0) ? 59 : 0));
		return HW'($urandom_range(359));
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(rand_hue(), rand_pct(), rand_pct());
	endtask

	initial begin
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sector edges, wrap, saturation and value extremes, clamping
		send_request(9'd0, 7'd100, 7'd100);
		send_request(9'd59, 7'd100, 7'd100);
		send_request(9'd60, 7'd100, 7'd100);
		send_request(9'd119, 7'd100, 7'd100);
		send_request(9'd120, 7'd100, 7'd100);
		send_request(9'd179, 7'd100, 7'd100);
		send_request(9'd180, 7'd100, 7'd100);
		send_request(9'd239, 7'd100, 7'd100);
		send_request(9'd240, 7'd100, 7'd100);
		send_request(9'd299, 7'd100, 7'd100);
		send_request(9'd300, 7'd100, 7'd100);
		send_request(9'd359, 7'd100, 7'd100);
		send_request(9'd360, 7'd100, 7'd100);
		send_request(9'd419, 7'd75, 7'd90);
		send_request(9'd511, 7'd100, 7'd100);
		send_request(9'd256, 7'd50, 7'd50);
		send_request(9'd30, 7'd0, 7'd100);
		send_request(9'd200, 7'd100, 7'd0);
		send_request(9'd0, 7'd0, 7'd0);
		send_request(9'd90, 7'd127, 7'd127);
		send_request(9'd330, 7'd101, 7'd50);
		send_request(9'd45, 7'd63, 7'd101);
		send_request(9'd1, 7'd1, 7'd1);
		send_request(9'd150, 7'd99, 7'd33);

		// Back-pressure: long receiver hold-off while requests keep coming
		hold_req = 1'b1;
		send_random(40);

		// Random phases
		tx_idle_pct = 0;  rx_stall_pct = 0;  send_random(RANDOM_PER_PHASE);
		tx_idle_pct = 51; rx_stall_pct = 0;  send_random(RANDOM_PER_PHASE);
		tx_idle_pct = 0;  rx_stall_pct = 51; send_random(RANDOM_PER_PHASE);
		tx_idle_pct = 9;  rx_stall_pct = 9;  send_random(RANDOM_PER_PHASE);
		s_tvalid <= 1'b0;

		// Drain
		waited = 0;
		while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() > 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
